// ===== rtl/kms_pkg.sv =====
// Shared constants, types and reset values of the keypad matrix scanner.
package kms_pkg;

   localparam int ROWS = 4;
   localparam int COLS = 4;
   localparam int KEYS = ROWS * COLS;
   localparam int ROW_W = $clog2(ROWS);
   localparam int KEY_W = $clog2(KEYS);
   localparam int CHAR_W = 8;
   localparam int PART_W = (ROWS - 1) * COLS;

   localparam int HISTORY_DEPTH = 3;

   localparam int NUM_MAP_REGS = KEYS / 2;
   localparam int MAP_IDX_W = $clog2(NUM_MAP_REGS);
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W = 2 * CHAR_W;

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

   localparam logic [CSR_DATA_W-1:0] KEYMAP_RESET [NUM_MAP_REGS] = '{
      16'd12849, 16'd16691, 16'd13620, 16'd16950,
      16'd14391, 16'd17209, 16'd12330, 16'd17443
   };

   typedef struct packed {
      logic [ROW_W-1:0] next_row;
      logic             frame_done;
      logic             key_valid;
      logic [KEY_W-1:0] key_idx;
   } cmd_type;

endpackage

// ===== rtl/kms_if.sv =====
// Valid/ready channel interfaces for column samples and scan results.
interface kms_req_if import kms_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [COLS-1:0]  column_bits;

   modport source (output valid, output column_bits, input ready);
   modport sink (input valid, input column_bits, output ready);
endinterface

interface kms_rsp_if import kms_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ROW_W-1:0]  next_row;
   logic              frame_done;
   logic [CHAR_W-1:0] pressed_char;

   modport source (output valid, output next_row, output frame_done, output pressed_char,
                   input ready);
   modport sink (input valid, input next_row, input frame_done, input pressed_char,
                 output ready);
endinterface

// ===== rtl/kms_front.sv =====
// Front end: collects column samples into a frame and classifies the finished frame.
module kms_front import kms_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   kms_req_if.sink  req_if,
   output cmd_type  cmd,
   output logic     cmd_valid,
   input  logic     cmd_ready
);

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [PART_W-1:0] part_ff, part_in;
   logic [KEYS-1:0]   frame;
   logic              one_key;
   logic [KEY_W-1:0]  key_idx;
   logic              take;

   assign take = req_if.valid && cmd_ready;
   assign req_if.ready = cmd_ready;
   assign cmd_valid = req_if.valid;
   assign frame = {req_if.column_bits, part_ff};
   assign one_key = (frame != '0) && ((frame & (frame - KEYS'(1))) == '0);

   always_comb begin
      key_idx = '0;
      for (int i = 0; i < KEYS; i++) begin
         if (frame[i]) begin
            key_idx = key_idx | KEY_W'(i);
         end
      end
   end

   always_comb begin
      part_in = part_ff;
      row_in = row_ff;
      if (row_ff == LAST_ROW) begin
         part_in = '0;
         row_in = '0;
      end else begin
         for (int r = 0; r < ROWS - 1; r++) begin
            if (row_ff == ROW_W'(r)) begin
               part_in[r*COLS +: COLS] = req_if.column_bits;
            end
         end
         row_in = row_ff + ROW_W'(1);
      end
   end

   always_comb begin
      cmd.next_row = row_in;
      cmd.frame_done = (row_ff == LAST_ROW);
      cmd.key_valid = one_key;
      cmd.key_idx = key_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         part_ff <= '0;
      end else if (take) begin
         row_ff <= row_in;
         part_ff <= part_in;
      end
   end

endmodule

// ===== rtl/kms_fifo.sv =====
// Short queue of classified transactions between the front and back ends.
module kms_fifo import kms_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type push_data,
   input  logic    push_valid,
   output logic    push_ready,
   output cmd_type pop_data,
   output logic    pop_valid,
   input  logic    pop_ready
);

   cmd_type               slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff;
   logic                  push, pop;

   assign push_ready = (count_ff != FIFO_CNT_W'(FIFO_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                         : wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                         : rd_ptr_ff + FIFO_PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + FIFO_CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - FIFO_CNT_W'(1);
         end
      end
   end

endmodule

// ===== rtl/kms_back.sv =====
// Back end: key map lookup, character history, debounce and the result register.
module kms_back import kms_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   input  logic                   cmd_valid,
   output logic                   cmd_ready,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   kms_rsp_if.source              rsp_if
);

   logic [CSR_DATA_W-1:0] keymap_ff [NUM_MAP_REGS];
   logic [CHAR_W-1:0]     hist_ff [HISTORY_DEPTH-1];
   logic [CHAR_W-1:0]     debounced_ff, debounced_in;
   logic                  rsp_valid_ff;
   logic [ROW_W-1:0]      next_row_ff;
   logic                  frame_done_ff;
   logic [CSR_DATA_W-1:0] map_word;
   logic [CHAR_W-1:0]     frame_char;
   logic                  same;
   logic                  pop;

   assign pop = cmd_valid && (!rsp_valid_ff || rsp_if.ready);
   assign cmd_ready = !rsp_valid_ff || rsp_if.ready;

   assign map_word = keymap_ff[cmd.key_idx[KEY_W-1:1]];

   always_comb begin
      if (!cmd.key_valid) begin
         frame_char = SPACE_CHAR;
      end else if (cmd.key_idx[0]) begin
         frame_char = map_word[CSR_DATA_W-1:CHAR_W];
      end else begin
         frame_char = map_word[CHAR_W-1:0];
      end
   end

   always_comb begin
      same = 1'b1;
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
         if (hist_ff[i] != frame_char) begin
            same = 1'b0;
         end
      end
      if (!cmd.frame_done) begin
         debounced_in = debounced_ff;
      end else if (same) begin
         debounced_in = frame_char;
      end else begin
         debounced_in = SPACE_CHAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_MAP_REGS; i++) begin
            keymap_ff[i] <= KEYMAP_RESET[i];
         end
      end else if (csr_we && (csr_index < CSR_INDEX_W'(NUM_MAP_REGS))) begin
         keymap_ff[csr_index[MAP_IDX_W-1:0]] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
            hist_ff[i] <= '0;
         end
         debounced_ff <= SPACE_CHAR;
      end else if (pop && cmd.frame_done) begin
         hist_ff[0] <= frame_char;
         for (int i = 1; i < HISTORY_DEPTH - 1; i++) begin
            hist_ff[i] <= hist_ff[i-1];
         end
         debounced_ff <= debounced_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         next_row_ff <= cmd.next_row;
         frame_done_ff <= cmd.frame_done;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.next_row = next_row_ff;
   assign rsp_if.frame_done = frame_done_ff;
   assign rsp_if.pressed_char = debounced_ff;

endmodule

// ===== rtl/keypad_matrix_scanner_debounce.sv =====
// Top level of the 4x4 keypad matrix scanner with debounce.
//
// Each req transaction carries the four column levels of the row being driven; each one
// gives exactly one rsp transaction with the row to drive next, a flag for a completed
// four-row frame and the debounced key character (space when no key or several keys are
// down, or when the last HISTORY_DEPTH frames disagree). One transaction is taken per
// clock cycle while the queue has room; a sample passes through the two-entry queue
// between the frame collector and the lookup stage and then the result register, and the
// queue absorbs a stalled rsp side. Key map registers 0 to 7 hold two characters each
// (low byte for the even key) and should be written only while no transaction is in flight.
module keypad_matrix_scanner_debounce import kms_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   kms_req_if.sink                req_if,
   kms_rsp_if.source              rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cmd_type push_data, pop_data;
   logic    push_valid, push_ready, pop_valid, pop_ready;

   kms_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .cmd       (push_data),
      .cmd_valid (push_valid),
      .cmd_ready (push_ready)
   );

   kms_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_data   (pop_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   kms_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (pop_data),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_if    (rsp_if)
   );

`ifndef SYNTHESIS
   // A completed frame always sends the scan back to the first row.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.frame_done |-> rsp_if.next_row == '0)
      else $error("frame completion without return to row zero");

   // Mid-frame results never point at the first row.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.frame_done |-> rsp_if.next_row != '0)
      else $error("row sequence broken inside a frame");

   // A transaction entering an empty queue reaches the queue output next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready && !pop_valid |=> pop_valid)
      else $error("accepted transaction lost between front and queue");

   // The pressed character only changes when a frame completes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ready ##1 rsp_if.valid && !rsp_if.frame_done
      |-> rsp_if.pressed_char == $past(rsp_if.pressed_char))
      else $error("pressed character changed without a completed frame");
`endif

endmodule
